// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, all sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tlca_pkg.sv -----
package tlca_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

    // request kind carried on tuser
    typedef enum logic {
        REQ_EDGE  = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    // one table entry: parent node and distance from the root
    typedef struct packed {
        logic [NODE_W-1:0]  parent;
        logic [DEPTH_W-1:0] depth;
    } entry_t;

    typedef enum logic [1:0] {
        ALU_CMP,
        ALU_DEC,
        ALU_INC_SAT
    } alu_op_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } alu_flags_t;

endpackage

// ----- hw/rtl/tlca_ram.sv -----
module tlca_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tlca_alu.sv -----
module tlca_alu (
    input  tlca_pkg::alu_op_t                op,
    input  logic [tlca_pkg::NODE_W-1:0]      x,
    input  logic [tlca_pkg::NODE_W-1:0]      y,
    output logic [tlca_pkg::NODE_W-1:0]      result,
    output tlca_pkg::alu_flags_t             flags
);

    always_comb
    begin
        flags.gt = (x > y);
        flags.eq = (x == y);
        case (op)
            tlca_pkg::ALU_CMP:     result = x;
            tlca_pkg::ALU_DEC:     result = x - 10'd1;
            // depth saturates at the top of its range
            tlca_pkg::ALU_INC_SAT: result = (x == tlca_pkg::DEPTH_MAX) ? x : x + 10'd1;
            default:               result = x;
        endcase
    end

endmodule

// ----- hw/rtl/tree_lowest_common_ancestor_core.sv -----
// edge transaction: ST_E_RD reads the parent depth, ST_E_WR writes the child entry; no result
// query transaction: lift the deeper node to equal depth, then lift both jointly until they meet
// throughput: one transaction at a time, bounded by the single ram read port and the shared alu
// reset: asynchronous, active low; then a clearing pass zeroes every table entry
// while s_tready stays low
`include "assert_macros.svh"

module tree_lowest_common_ancestor_core #(
    parameter int NODES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // node_a [9:0], node_b [19:10], zero fill
    input  logic        s_tuser,   // req_type [0]: 0 add edge, 1 query
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ancestor [9:0], zero fill
);

    localparam int AW = $clog2(NODES);
    localparam int NW = tlca_pkg::NODE_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_E_RD,
        ST_E_WR,
        ST_Q_A,
        ST_Q_B,
        ST_Q_DB,
        ST_DECIDE,
        ST_LIFT_A,
        ST_LIFT_B,
        ST_MEET,
        ST_MA,
        ST_MB
    } state_t;

    function automatic logic in_range(input logic [NW-1:0] n);
        logic [31:0] ext;
        begin
            ext = {{(32-NW){1'b0}}, n};
            in_range = (ext < 32'(NODES));
        end
    endfunction

    // out-of-range nodes read entry 0, which always stays zero
    function automatic logic [AW-1:0] node_addr(input logic [NW-1:0] n);
        logic [31:0] ext;
        begin
            ext = {{(32-NW){1'b0}}, n};
            node_addr = (ext < 32'(NODES)) ? ext[AW-1:0] : '0;
        end
    endfunction

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]                 a_reg, a_next;
    logic [NW-1:0]                 b_reg, b_next;
    logic [tlca_pkg::DEPTH_W-1:0]  da_reg, da_next;
    logic [tlca_pkg::DEPTH_W-1:0]  db_reg, db_next;
    logic                          out_valid_reg, out_valid_next;
    logic [NW-1:0]                 out_data_reg, out_data_next;

    logic [NW-1:0]                 node_a;
    logic [NW-1:0]                 node_b;
    logic [NW-1:0]                 child;
    logic [NW-1:0]                 par;

    tlca_pkg::alu_op_t             alu_op;
    logic [NW-1:0]                 alu_x;
    logic [NW-1:0]                 alu_y;
    logic [NW-1:0]                 alu_res;
    tlca_pkg::alu_flags_t          alu_flags;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    tlca_pkg::entry_t              ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    tlca_pkg::entry_t              ram_rdata;
    logic                          out_free;

    assign node_a = s_tdata[9:0];
    assign node_b = s_tdata[19:10];
    assign child  = alu_flags.gt ? node_a : node_b;
    assign par    = alu_flags.gt ? node_b : node_a;
    assign out_free = !out_valid_reg || m_tready;

    tlca_alu u_alu (
        .op     (alu_op),
        .x      (alu_x),
        .y      (alu_y),
        .result (alu_res),
        .flags  (alu_flags)
    );

    tlca_ram #(
        .WIDTH ($bits(tlca_pkg::entry_t)),
        .DEPTH (NODES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        out_data_next  = out_data_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;

        alu_op    = tlca_pkg::ALU_CMP;
        alu_x     = '0;
        alu_y     = '0;
        ram_we    = 1'b0;
        ram_waddr = node_addr(a_reg);
        ram_wdata = '0;
        ram_raddr = node_addr(a_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                alu_x = node_a;
                alu_y = node_b;
                if (s_tvalid)
                begin
                    a_next = node_a;
                    b_next = node_b;
                    if (s_tuser == tlca_pkg::REQ_QUERY)
                    begin
                        state_next = ST_Q_A;
                    end
                    else if (!alu_flags.eq && in_range(child))
                    begin
                        a_next     = child;
                        b_next     = par;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_E_RD:
            begin
                ram_raddr  = node_addr(b_reg);
                state_next = ST_E_WR;
            end
            ST_E_WR:
            begin
                alu_op           = tlca_pkg::ALU_INC_SAT;
                alu_x            = ram_rdata.depth;
                ram_we           = 1'b1;
                ram_waddr        = node_addr(a_reg);
                ram_wdata.parent = b_reg;
                ram_wdata.depth  = alu_res;
                state_next       = ST_IDLE;
            end
            ST_Q_A:
            begin
                ram_raddr  = node_addr(a_reg);
                state_next = ST_Q_B;
            end
            ST_Q_B:
            begin
                da_next    = ram_rdata.depth;
                ram_raddr  = node_addr(b_reg);
                state_next = ST_Q_DB;
            end
            ST_Q_DB:
            begin
                db_next    = ram_rdata.depth;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                alu_x = da_reg;
                alu_y = db_reg;
                ram_raddr = alu_flags.gt ? node_addr(a_reg) : node_addr(b_reg);
                if (alu_flags.eq)
                begin
                    state_next = ST_MEET;
                end
                else if (alu_flags.gt)
                begin
                    state_next = ST_LIFT_A;
                end
                else
                begin
                    state_next = ST_LIFT_B;
                end
            end
            ST_LIFT_A:
            begin
                alu_op     = tlca_pkg::ALU_DEC;
                alu_x      = da_reg;
                a_next     = ram_rdata.parent;
                da_next    = alu_res;
                state_next = ST_DECIDE;
            end
            ST_LIFT_B:
            begin
                alu_op     = tlca_pkg::ALU_DEC;
                alu_x      = db_reg;
                b_next     = ram_rdata.parent;
                db_next    = alu_res;
                state_next = ST_DECIDE;
            end
            ST_MEET:
            begin
                alu_x     = a_reg;
                alu_y     = b_reg;
                ram_raddr = node_addr(a_reg);
                if (!alu_flags.eq)
                begin
                    state_next = ST_MA;
                end
                else if (out_free)
                begin
                    // walks met: hand the node to the output register
                    out_valid_next = 1'b1;
                    out_data_next  = a_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_MA:
            begin
                a_next     = ram_rdata.parent;
                ram_raddr  = node_addr(b_reg);
                state_next = ST_MB;
            end
            ST_MB:
            begin
                b_next     = ram_rdata.parent;
                state_next = ST_MEET;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-NW){1'b0}}, out_data_reg};

    `ASSERT_IMP(a_no_result_in_clear, state_reg == ST_CLEAR, !out_valid_reg, "result during clearing pass")
    `ASSERT_IMP(a_lift_a_deeper, state_reg == ST_LIFT_A, da_reg > db_reg, "lifting a while not deeper")
    `ASSERT_IMP(a_lift_b_deeper, state_reg == ST_LIFT_B, db_reg > da_reg, "lifting b while not deeper")
    `ASSERT_NEXT(a_meet_level, state_reg == ST_MEET, da_reg == db_reg, "joint walk at unequal depth")

endmodule
